FILE: hdl/drfw_pkg.sv
package drfw_pkg;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned FRAME_W = 12;
	localparam int unsigned SPAN_W  = 13;
	localparam int unsigned WIDE_W  = 18;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;

	// Request codes.
	localparam logic [2:0] REQ_PIXEL   = 3'd0;
	localparam logic [2:0] REQ_RECT    = 3'd1;
	localparam logic [2:0] REQ_CLIP    = 3'd2;
	localparam logic [2:0] REQ_FLUSH   = 3'd3;
	localparam logic [2:0] REQ_REFRESH = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_ASLEEP = 2'd3;

	localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 12'd480;
	localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 12'd320;
	localparam logic [FRAME_W-1:0] PANEL_WIDTH_RST  = 12'd320;

	// Windows are aligned to four pixels.
	localparam logic [1:0] ALIGN_BITS = 2'b11;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_width;
		logic [FRAME_W-1:0] frame_height;
		logic [FRAME_W-1:0] panel_width;
		logic               panel_asleep;
	} cfg_t;

	typedef struct packed {
		logic        [2:0]         kind;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] w;
		logic signed [COORD_W-1:0] h;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] wide;
		logic signed [COORD_W-1:0] tall;
	} clip_t;

	typedef struct packed {
		logic               window_valid;
		logic [FRAME_W-1:0] panel_x;
		logic [FRAME_W-1:0] panel_y;
		logic [SPAN_W-1:0]  panel_w;
		logic [SPAN_W-1:0]  panel_h;
	} result_t;

	function automatic logic signed [WIDE_W-1:0] sx_wide(input logic [COORD_W-1:0] v);
		return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

	function automatic logic signed [WIDE_W-1:0] zx_wide(input logic [FRAME_W-1:0] v);
		return {{(WIDE_W-FRAME_W){1'b0}}, v};
	endfunction

endpackage

FILE: hdl/drfw_flush.sv
module drfw_flush (
	input  logic signed [drfw_pkg::WIDE_W-1:0] x1,
	input  logic signed [drfw_pkg::WIDE_W-1:0] y1,
	input  logic signed [drfw_pkg::WIDE_W-1:0] x2,
	input  logic signed [drfw_pkg::WIDE_W-1:0] y2,
	input  drfw_pkg::cfg_t                     cfg,
	input  drfw_pkg::clip_t                    clip,
	output drfw_pkg::result_t                  res
);
	import drfw_pkg::*;

	logic                       clip_active;
	logic signed [WIDE_W-1:0]   cl, ct, cr, cb;
	logic signed [WIDE_W-1:0]   fw, fh;
	logic signed [WIDE_W-1:0]   a1, b1, a2, b2;
	logic signed [WIDE_W-1:0]   c1, d1, c2, d2;
	logic                       empty_cut, empty_clamp;
	logic [FRAME_W-1:0]         l_al, t_al, r_or, b_or, r_f, b_f;
	logic [SPAN_W-1:0]          span_x, span_y;

	always_comb begin
		clip_active = (clip.wide > 0) && (clip.tall > 0);
		cl = sx_wide(clip.left);
		ct = sx_wide(clip.top);
		cr = sx_wide(clip.left) + sx_wide(clip.wide) - 18'sd1;
		cb = sx_wide(clip.top) + sx_wide(clip.tall) - 18'sd1;
		fw = zx_wide(cfg.frame_width);
		fh = zx_wide(cfg.frame_height);

		a1 = (clip_active && cl > x1) ? cl : x1;
		b1 = (clip_active && ct > y1) ? ct : y1;
		a2 = (clip_active && cr < x2) ? cr : x2;
		b2 = (clip_active && cb < y2) ? cb : y2;
		empty_cut = (a1 > a2) || (b1 > b2);

		c1 = (a1 < 0) ? '0 : a1;
		d1 = (b1 < 0) ? '0 : b1;
		c2 = (a2 >= fw) ? fw - 18'sd1 : a2;
		d2 = (b2 >= fh) ? fh - 18'sd1 : b2;
		empty_clamp = (c1 > c2) || (d1 > d2);

		// When not empty all four bounds lie inside the frame and fit twelve bits.
		l_al = {c1[FRAME_W-1:2], ~ALIGN_BITS & 2'b00};
		t_al = {d1[FRAME_W-1:2], ~ALIGN_BITS & 2'b00};
		r_or = {c2[FRAME_W-1:2], ALIGN_BITS};
		b_or = {d2[FRAME_W-1:2], ALIGN_BITS};
		r_f = (r_or >= cfg.frame_width) ? cfg.frame_width - 12'd1 : r_or;
		b_f = (b_or >= cfg.frame_height) ? cfg.frame_height - 12'd1 : b_or;

		span_x = {1'b0, r_f} - {1'b0, l_al} + 13'd1;
		span_y = {1'b0, b_f} - {1'b0, t_al} + 13'd1;

		res = '0;
		if (!empty_cut && !empty_clamp) begin
			res.window_valid = 1'b1;
			res.panel_x = cfg.panel_width - b_f - 12'd1;
			res.panel_y = l_al;
			res.panel_w = span_y;
			res.panel_h = span_x;
		end
	end

endmodule

FILE: hdl/drfw_core.sv
module drfw_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  drfw_pkg::req_t    req,
	input  drfw_pkg::cfg_t    cfg,
	output drfw_pkg::result_t res
);
	import drfw_pkg::*;

	logic               box_valid_q;
	logic [FRAME_W-1:0] box_left_q, box_top_q, box_right_q, box_bottom_q;
	clip_t              clip_q;

	logic signed [WIDE_W-1:0] x, y, w, h, fw, fh, rx2, ry2;
	logic                     merge_en, flush_go;
	logic [FRAME_W-1:0]       ml, mt, mr, mb;
	logic signed [WIDE_W-1:0] fx1, fy1, fx2, fy2;
	result_t                  fres;

	always_comb begin
		x  = sx_wide(req.x);
		y  = sx_wide(req.y);
		w  = sx_wide(req.w);
		h  = sx_wide(req.h);
		fw = zx_wide(cfg.frame_width);
		fh = zx_wide(cfg.frame_height);

		rx2 = x + w - 18'sd1;
		ry2 = y + h - 18'sd1;
		if (rx2 >= fw) rx2 = fw - 18'sd1;
		if (ry2 >= fh) ry2 = fh - 18'sd1;

		merge_en = 1'b0;
		flush_go = 1'b0;
		ml = x[FRAME_W-1:0];
		mt = y[FRAME_W-1:0];
		mr = x[FRAME_W-1:0];
		mb = y[FRAME_W-1:0];
		fx1 = zx_wide(box_left_q);
		fy1 = zx_wide(box_top_q);
		fx2 = zx_wide(box_right_q);
		fy2 = zx_wide(box_bottom_q);

		unique case (req.kind)
			REQ_PIXEL: begin
				merge_en = (x >= 0) && (y >= 0) && (x < fw) && (y < fh);
			end
			REQ_RECT: begin
				merge_en = (w > 0) && (h > 0) && (x >= 0) && (y >= 0) &&
					(rx2 >= x) && (ry2 >= y);
				mr = rx2[FRAME_W-1:0];
				mb = ry2[FRAME_W-1:0];
			end
			REQ_FLUSH: begin
				flush_go = box_valid_q;
			end
			REQ_REFRESH: begin
				flush_go = 1'b1;
				fx1 = '0;
				fy1 = '0;
				fx2 = fw - 18'sd1;
				fy2 = fh - 18'sd1;
			end
			default: begin
			end
		endcase
	end

	drfw_flush u_flush (
		.x1   (fx1),
		.y1   (fy1),
		.x2   (fx2),
		.y2   (fy2),
		.cfg  (cfg),
		.clip (clip_q),
		.res  (fres)
	);

	assign res = (flush_go && !cfg.panel_asleep) ? fres : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q  <= 1'b0;
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_right_q  <= '0;
			box_bottom_q <= '0;
			clip_q       <= '0;
		end else if (fire) begin
			if (merge_en) begin
				box_valid_q <= 1'b1;
				if (!box_valid_q || ml < box_left_q) box_left_q <= ml;
				if (!box_valid_q || mt < box_top_q) box_top_q <= mt;
				if (!box_valid_q || mr > box_right_q) box_right_q <= mr;
				if (!box_valid_q || mb > box_bottom_q) box_bottom_q <= mb;
			end
			if (req.kind == REQ_CLIP) begin
				if (req.w <= 0 || req.h <= 0) begin
					clip_q.wide <= '0;
					clip_q.tall <= '0;
				end else begin
					clip_q <= '{left: req.x, top: req.y, wide: req.w, tall: req.h};
				end
			end
			// A flush of a valid box or a refresh, sent or discarded, consumes both the box and the clip.
			if (flush_go) begin
				box_valid_q <= 1'b0;
				clip_q.wide <= '0;
				clip_q.tall <= '0;
			end
		end
	end

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && flush_go |=> !box_valid_q && clip_q.wide == 0 && clip_q.tall == 0)
		else $error("flush left box or clip behind");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid_q |-> box_left_q <= box_right_q && box_top_q <= box_bottom_q)
		else $error("dirty box corners out of order");

	a_window_size: assert property (@(posedge clk) disable iff (!arst_n)
		res.window_valid |-> res.panel_w != 0 && res.panel_h != 0 && flush_go)
		else $error("emitted window has no size");

endmodule

FILE: hdl/dirty_rect_rotated_flush_window_top.sv
// Dirty-rectangle tracker: pixel and rectangle marks grow one bounding box over the
// landscape frame, a clip request limits the next flush, and a flush or full refresh
// returns the box rounded out to 4-pixel multiples and rotated into portrait panel
// coordinates. Every request gives exactly one result transfer; window_valid tells
// whether it carries a window. A request passes the input register, then the result
// register; one request is taken every cycle while out_stall is low, since all decode, merge
// and window math sits in one level of logic between those registers. The user must write
// configuration via wr_en/wr_index/wr_data only while idle; the block does not enforce it.
module dirty_rect_rotated_flush_window_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [drfw_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [drfw_pkg::CFG_DATA_W-1:0]       wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [2:0]                            req_type,
	input  logic signed [drfw_pkg::COORD_W-1:0]   x_coord,
	input  logic signed [drfw_pkg::COORD_W-1:0]   y_coord,
	input  logic signed [drfw_pkg::COORD_W-1:0]   rect_width,
	input  logic signed [drfw_pkg::COORD_W-1:0]   rect_height,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  window_valid,
	output logic [drfw_pkg::FRAME_W-1:0]          panel_x,
	output logic [drfw_pkg::FRAME_W-1:0]          panel_y,
	output logic [drfw_pkg::SPAN_W-1:0]           panel_w,
	output logic [drfw_pkg::SPAN_W-1:0]           panel_h
);
	import drfw_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1, valid_s2;
	req_t    req_s1;
	result_t res_s2, res_comb;
	logic    advance, accept;

	// The input register moves on whenever the result register is free or draining.
	assign advance  = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{frame_width: FRAME_WIDTH_RST, frame_height: FRAME_HEIGHT_RST,
				panel_width: PANEL_WIDTH_RST, panel_asleep: 1'b0};
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_FRAME_WIDTH:  cfg_q.frame_width  <= wr_data;
				CFG_FRAME_HEIGHT: cfg_q.frame_height <= wr_data;
				CFG_PANEL_WIDTH:  cfg_q.panel_width  <= wr_data;
				CFG_PANEL_ASLEEP: cfg_q.panel_asleep <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= '{kind: req_type, x: x_coord, y: y_coord, w: rect_width,
				h: rect_height};
		end
	end

	drfw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.cfg    (cfg_q),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid    = valid_s2;
	assign window_valid = res_s2.window_valid;
	assign panel_x      = res_s2.panel_x;
	assign panel_y      = res_s2.panel_y;
	assign panel_w      = res_s2.panel_w;
	assign panel_h      = res_s2.panel_h;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with a free input register");

	a_item_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("request did not reach the result register");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(res_s2))
		else $error("stalled result changed or vanished");

endmodule

FILE: dv/testbench.sv
module testbench;
	import drfw_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]      wr_index = '0;
	logic [CFG_DATA_W-1:0]     wr_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [2:0]                req_type = REQ_PIXEL;
	logic signed [COORD_W-1:0] x_coord = '0;
	logic signed [COORD_W-1:0] y_coord = '0;
	logic signed [COORD_W-1:0] rect_width = '0;
	logic signed [COORD_W-1:0] rect_height = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      window_valid;
	logic [FRAME_W-1:0]        panel_x;
	logic [FRAME_W-1:0]        panel_y;
	logic [SPAN_W-1:0]         panel_w;
	logic [SPAN_W-1:0]         panel_h;

	dirty_rect_rotated_flush_window_top i_dut (.*);

	always #5 clk = ~clk;

	// Copy of the block's registers and dirty/clip state, kept by the predictor.
	cfg_t cfg_now = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, PANEL_WIDTH_RST, 1'b0};
	bit   dirty_valid = 1'b0;
	int   dirty_left = 0, dirty_top = 0, dirty_right = 0, dirty_bottom = 0;
	int   clip_left = 0, clip_top = 0, clip_wide = 0, clip_tall = 0;

	result_t window_q[$];
	int      mismatch_count = 0;
	int      send_idle_pct = 13;
	int      recv_idle_pct = 64;
	int      idle_cycles = 0;

	function automatic void grow_box(input int l, input int t, input int r, input int b);
		if (!dirty_valid) begin
			dirty_left = l;
			dirty_top = t;
			dirty_right = r;
			dirty_bottom = b;
			dirty_valid = 1'b1;
		end else begin
			if (l < dirty_left) dirty_left = l;
			if (r > dirty_right) dirty_right = r;
			if (t < dirty_top) dirty_top = t;
			if (b > dirty_bottom) dirty_bottom = b;
		end
	endfunction

	function automatic result_t flush_box(input int x1, input int y1, input int x2, input int y2);
		result_t res;
		int      fw, fh, wide, tall, px;
		res = '0;
		fw = cfg_now.frame_width;
		fh = cfg_now.frame_height;
		if (cfg_now.panel_asleep) begin
			dirty_valid = 1'b0;
			clip_wide = 0;
			clip_tall = 0;
			return res;
		end
		if (clip_wide > 0 && clip_tall > 0) begin
			if (clip_left > x1) x1 = clip_left;
			if (clip_top > y1) y1 = clip_top;
			if (clip_left + clip_wide - 1 < x2) x2 = clip_left + clip_wide - 1;
			if (clip_top + clip_tall - 1 < y2) y2 = clip_top + clip_tall - 1;
			clip_wide = 0;
			clip_tall = 0;
		end
		dirty_valid = 1'b0;
		if (x1 > x2 || y1 > y2) return res;
		if (x1 < 0) x1 = 0;
		if (y1 < 0) y1 = 0;
		if (x2 >= fw) x2 = fw - 1;
		if (y2 >= fh) y2 = fh - 1;
		if (x1 > x2 || y1 > y2) return res;
		// Round out to the 4-pixel grid, then pull the far edge back into the frame.
		x1 = x1 & ~int'(ALIGN_BITS);
		y1 = y1 & ~int'(ALIGN_BITS);
		x2 = x2 | int'(ALIGN_BITS);
		y2 = y2 | int'(ALIGN_BITS);
		if (x2 >= fw) x2 = fw - 1;
		if (y2 >= fh) y2 = fh - 1;
		wide = x2 - x1 + 1;
		tall = y2 - y1 + 1;
		px = int'(cfg_now.panel_width) - y2 - 1;
		res.window_valid = 1'b1;
		res.panel_x = px[FRAME_W-1:0];
		res.panel_y = x1[FRAME_W-1:0];
		res.panel_w = tall[SPAN_W-1:0];
		res.panel_h = wide[SPAN_W-1:0];
		return res;
	endfunction

	function automatic result_t predict_window(input req_t r);
		result_t res;
		int      x, y, w, h, x2, y2, fw, fh;
		res = '0;
		x = $signed(r.x);
		y = $signed(r.y);
		w = $signed(r.w);
		h = $signed(r.h);
		fw = cfg_now.frame_width;
		fh = cfg_now.frame_height;
		case (r.kind)
			REQ_PIXEL: begin
				if (x >= 0 && y >= 0 && x < fw && y < fh) grow_box(x, y, x, y);
			end
			REQ_RECT: begin
				if (w > 0 && h > 0) begin
					x2 = x + w - 1;
					y2 = y + h - 1;
					if (x2 >= fw) x2 = fw - 1;
					if (y2 >= fh) y2 = fh - 1;
					if (x >= 0 && y >= 0 && x2 >= x && y2 >= y) grow_box(x, y, x2, y2);
				end
			end
			REQ_CLIP: begin
				// A clip with no size only disables the window; its origin is kept.
				if (w <= 0 || h <= 0) begin
					clip_wide = 0;
					clip_tall = 0;
				end else begin
					clip_left = x;
					clip_top = y;
					clip_wide = w;
					clip_tall = h;
				end
			end
			REQ_FLUSH: begin
				if (dirty_valid) res = flush_box(dirty_left, dirty_top, dirty_right, dirty_bottom);
			end
			REQ_REFRESH: begin
				res = flush_box(0, 0, fw - 1, fh - 1);
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic req_t mk_req(input logic [2:0] kind, input int x, input int y,
			input int w, input int h);
		req_t r;
		r.kind = kind;
		r.x = 16'(x);
		r.y = 16'(y);
		r.w = 16'(w);
		r.h = 16'(h);
		return r;
	endfunction

	task automatic send_req(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		x_coord <= r.x;
		y_coord <= r.y;
		rect_width <= r.w;
		rect_height <= r.h;
		do @(posedge clk); while (in_stall !== 1'b0);
		window_q.push_back(predict_window(r));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (window_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_FRAME_WIDTH:  cfg_now.frame_width = data;
			CFG_FRAME_HEIGHT: cfg_now.frame_height = data;
			CFG_PANEL_WIDTH:  cfg_now.panel_width = data;
			CFG_PANEL_ASLEEP: cfg_now.panel_asleep = data[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int fw, input int fh, input int pw, input bit asleep);
		drain_results();
		cfg_write(CFG_FRAME_WIDTH, 12'(fw));
		cfg_write(CFG_FRAME_HEIGHT, 12'(fh));
		cfg_write(CFG_PANEL_WIDTH, 12'(pw));
		cfg_write(CFG_PANEL_ASLEEP, {11'b0, asleep});
	endtask

	task automatic test_marks();
		send_req(mk_req(REQ_PIXEL, 0, 0, 0, 0));
		send_req(mk_req(REQ_PIXEL, 479, 319, 0, 0));
		send_req(mk_req(REQ_PIXEL, 480, 5, 0, 0));
		send_req(mk_req(REQ_PIXEL, -32768, 32767, -1, -1));
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		send_req(mk_req(REQ_RECT, 5, 6, 32767, 32767));
		send_req(mk_req(REQ_RECT, 10, 10, 0, 5));
		send_req(mk_req(REQ_RECT, 10, 10, 5, -32768));
		send_req(mk_req(REQ_RECT, -1, 10, 5, 5));
		send_req(mk_req(REQ_RECT, 480, 10, 5, 5));
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		drain_results();
	endtask

	task automatic test_clip();
		send_req(mk_req(REQ_CLIP, 100, 50, 40, 30));
		// With no box the flush must leave the clip in place for the next one.
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		send_req(mk_req(REQ_RECT, 90, 40, 30, 30));
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		send_req(mk_req(REQ_CLIP, 200, 200, 10, 10));
		send_req(mk_req(REQ_PIXEL, 10, 10, 0, 0));
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		send_req(mk_req(REQ_CLIP, 7, 9, 20, 20));
		send_req(mk_req(REQ_CLIP, 0, 0, 0, 5));
		send_req(mk_req(REQ_REFRESH, 0, 0, 0, 0));
		send_req(mk_req(3'd5, 32767, 32767, 32767, 32767));
		send_req(mk_req(3'd6, 1, 1, 1, 1));
		send_req(mk_req(3'd7, -1, -1, -1, -1));
		drain_results();
	endtask

	task automatic test_config_corners();
		set_config(480, 320, 320, 1'b1);
		send_req(mk_req(REQ_PIXEL, 3, 3, 0, 0));
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		send_req(mk_req(REQ_REFRESH, 0, 0, 0, 0));
		set_config(4095, 4095, 4095, 1'b0);
		send_req(mk_req(REQ_RECT, 0, 0, 32767, 32767));
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		set_config(1, 1, 1, 1'b0);
		send_req(mk_req(REQ_REFRESH, 0, 0, 0, 0));
		// A box reaching the bottom row of a 321-row frame on a 320-wide panel wraps panel_x.
		set_config(481, 321, 320, 1'b0);
		send_req(mk_req(REQ_RECT, 477, 317, 10, 10));
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		set_config(480, 320, 320, 1'b0);
		send_req(mk_req(REQ_PIXEL, 400, 300, 0, 0));
		set_config(100, 100, 320, 1'b0);
		send_req(mk_req(REQ_FLUSH, 0, 0, 0, 0));
		set_config(0, 320, 320, 1'b0);
		send_req(mk_req(REQ_PIXEL, 0, 0, 0, 0));
		send_req(mk_req(REQ_REFRESH, 0, 0, 0, 0));
		drain_results();
	endtask

	function automatic int pick_size();
		case ($urandom_range(3))
			0: return $urandom_range(32, 1);
			3: return $urandom_range(4095, 641);
			default: return $urandom_range(640, 33);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_coord(input int limit);
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'(limit - 2 + int'($urandom_range(3)));
			default: return 16'($urandom_range(limit - 1));
		endcase
	endfunction

	function automatic logic signed [15:0] pick_span(input int limit);
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'(-int'($urandom_range(2)));
			2: return 16'($urandom_range(limit + 8, 1));
			default: return 16'($urandom_range(24, 1));
		endcase
	endfunction

	function automatic req_t random_req();
		req_t r;
		int   sel, fw, fh;
		fw = (cfg_now.frame_width == 0) ? 1 : int'(cfg_now.frame_width);
		fh = (cfg_now.frame_height == 0) ? 1 : int'(cfg_now.frame_height);
		sel = $urandom_range(99);
		r.x = pick_coord(fw);
		r.y = pick_coord(fh);
		r.w = pick_span(fw);
		r.h = pick_span(fh);
		if (sel < 30) r.kind = REQ_PIXEL;
		else if (sel < 55) r.kind = REQ_RECT;
		else if (sel < 65) r.kind = REQ_CLIP;
		else if (sel < 80) r.kind = REQ_FLUSH;
		else if (sel < 85) r.kind = REQ_REFRESH;
		else r = mk_req(3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom);
		return r;
	endfunction

	task automatic test_random();
		int blk_pct[3][2] = '{'{13, 64}, '{64, 13}, '{0, 0}};
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = blk_pct[phase][0];
			recv_idle_pct = blk_pct[phase][1];
			for (int blk = 0; blk < 4; blk++) begin
				set_config(pick_size(), pick_size(), 0, 1'b0);
				set_config(cfg_now.frame_width, cfg_now.frame_height,
						($urandom_range(9) == 0) ? $urandom_range(4095, 1)
						: $urandom_range(4095, cfg_now.frame_height),
						$urandom_range(9) == 0);
				for (int n = 0; n < 88; n++) begin
					send_req(random_req());
					if (blk == 1 && n == 40) drain_results();
				end
			end
		end
		drain_results();
	endtask

	function automatic void check_field(input string name, input logic [12:0] want,
			input logic [12:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Each result transfer is compared with the oldest window still expected.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (window_q.size() == 0) begin
					$error("result transfer with no request outstanding");
					mismatch_count++;
				end else begin
					want = window_q.pop_front();
					check_field("window_valid", 13'(want.window_valid), 13'(window_valid));
					check_field("panel_x", 13'(want.panel_x), 13'(panel_x));
					check_field("panel_y", 13'(want.panel_y), 13'(panel_y));
					check_field("panel_w", want.panel_w, panel_w);
					check_field("panel_h", want.panel_h, panel_h);
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("** dirty_rect_rotated_flush_window_top: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_marks();
		test_clip();
		test_config_corners();
		test_random();
		if (mismatch_count == 0) begin
			$display("** dirty_rect_rotated_flush_window_top: PASSED **");
		end else begin
			$display("** dirty_rect_rotated_flush_window_top: FAILED **");
		end
		$finish;
	end

endmodule
